// ===== sv/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, command and status codes, and sequencer states for the
// fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 64;

  // Stream payload widths, packed fields rounded up to whole bytes.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_ALLOC   = 3'd1;
  localparam logic [2:0] CMD_FREE    = 3'd2;
  localparam logic [2:0] CMD_RELEASE = 3'd3;
  localparam logic [2:0] CMD_FORCE   = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_HANDLE  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [2:0] ST_NO_CAPACITY = 3'd3;
  localparam logic [2:0] ST_IN_USE      = 3'd4;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_SCAN_RD  = 8'b0000_0100,
    S_SCAN_CHK = 8'b0000_1000,
    S_FREE_RD  = 8'b0001_0000,
    S_FREE_CHK = 8'b0010_0000,
    S_APPEND   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } seq_state_t;

endpackage

// ===== sv/fixed_block_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Pool allocator for fixed-size blocks named by 1-based handles. The in-use
// flags live in a one-bit RAM that a small sequencer walks one entry at a time.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents (low bit first)
//   s_*      in   cmd[2:0], block_request[12:3], handle_in[19:13]
//   m_*      out  status[2:0], handle_out[9:3], total_blocks[16:10],
//                 free_blocks[23:17]
//
// One command is in flight at a time; s_tready is high only when idle.
// Alloc walks the flags from the lowest index up and takes the lowest free
// block, reading each flag through the RAM port; when no block is free it
// appends one if the pool is below MAX_BLOCKS. After reset, the flag RAM is
// swept before the first beat is taken. Init or force release with blocks in
// use sweeps the old pool.
// A finished result waits in the output register while m_tready is low.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit
  import fbpa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // cmd[2:0], block_request[12:3], handle_in[19:13], zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // status[2:0], handle_out[9:3], total_blocks[16:10], free_blocks[23:17]
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned XW = (CW > 11) ? CW : 11;

  seq_state_t    state;
  logic [CW-1:0] pool_size;
  logic [CW-1:0] used_cnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] clr_end;
  logic          clr_report;
  logic [2:0]    res_status;
  logic [CW-1:0] res_handle;

  logic [2:0]    in_cmd;
  logic [9:0]    in_req;
  logic [6:0]    in_handle;
  logic          accept;
  logic [XW-1:0] req_x;
  logic [XW-1:0] hnd_in_x;
  logic [CW-1:0] init_size;
  logic          init_sat;

  logic          ram_we;
  logic [0:0]    ram_wdata;
  logic [0:0]    ram_rdata;

  logic [XW-1:0] total_x;
  logic [XW-1:0] free_x;
  logic [XW-1:0] hnd_out_x;
  logic          out_free;

  assign in_cmd    = s_tdata[2:0];
  assign in_req    = s_tdata[12:3];
  assign in_handle = s_tdata[19:13];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign req_x     = XW'(in_req);
  assign hnd_in_x  = XW'(in_handle);
  assign init_sat  = (req_x > XW'(MAX_BLOCKS));
  assign init_size = init_sat ? CW'(MAX_BLOCKS) : CW'(in_req);

  assign total_x   = XW'(pool_size);
  assign free_x    = XW'(pool_size - used_cnt);
  assign hnd_out_x = XW'(res_handle);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
      end
      S_SCAN_CHK: begin
        ram_we    = !ram_rdata[0];
        ram_wdata = 1'b1;
      end
      S_FREE_CHK: begin
        ram_we = ram_rdata[0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fbpa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BLOCKS)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pool_size  <= '0;
      used_cnt   <= '0;
      idx        <= '0;
      clr_end    <= CW'(MAX_BLOCKS);
      clr_report <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // A new beat loaded in S_DONE takes the place of the one leaving.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          idx <= CW'(idx + 1'b1);
          if (CW'(idx + 1'b1) == clr_end) begin
            state <= clr_report ? S_DONE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            res_handle <= '0;
            case (in_cmd)
              CMD_INIT: begin
                res_status <= init_sat ? ST_NO_CAPACITY : ST_OK;
                pool_size  <= init_size;
                used_cnt   <= '0;
                // Flags of the old pool must be cleared before reuse.
                if (used_cnt != '0) begin
                  idx        <= '0;
                  clr_end    <= pool_size;
                  clr_report <= 1'b1;
                  state      <= S_CLEAR;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_ALLOC: begin
                if (used_cnt != pool_size) begin
                  res_status <= ST_OK;
                  idx        <= '0;
                  state      <= S_SCAN_RD;
                end else if (pool_size < CW'(MAX_BLOCKS)) begin
                  res_status <= ST_OK;
                  idx        <= pool_size;
                  state      <= S_APPEND;
                end else begin
                  res_status <= ST_NO_CAPACITY;
                  state      <= S_DONE;
                end
              end
              CMD_FREE: begin
                if (hnd_in_x == '0) begin
                  res_status <= ST_BAD_HANDLE;
                  state      <= S_DONE;
                end else if (hnd_in_x > XW'(pool_size)) begin
                  res_status <= ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  idx        <= CW'(hnd_in_x - 1'b1);
                  state      <= S_FREE_RD;
                end
              end
              CMD_RELEASE: begin
                state <= S_DONE;
                if (used_cnt != '0) begin
                  res_status <= ST_IN_USE;
                end else begin
                  res_status <= ST_OK;
                  pool_size  <= '0;
                end
              end
              CMD_FORCE: begin
                res_status <= ST_OK;
                pool_size  <= '0;
                used_cnt   <= '0;
                if (used_cnt != '0) begin
                  idx        <= '0;
                  clr_end    <= pool_size;
                  clr_report <= 1'b1;
                  state      <= S_CLEAR;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end

        S_SCAN_CHK: begin
          // A free entry below pool_size is known to exist, so the walk ends.
          if (!ram_rdata[0]) begin
            used_cnt   <= CW'(used_cnt + 1'b1);
            res_handle <= CW'(idx + 1'b1);
            state      <= S_DONE;
          end else begin
            idx   <= CW'(idx + 1'b1);
            state <= S_SCAN_RD;
          end
        end

        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end

        S_FREE_CHK: begin
          if (ram_rdata[0]) begin
            used_cnt <= CW'(used_cnt - 1'b1);
          end
          state <= S_DONE;
        end

        S_APPEND: begin
          pool_size  <= CW'(pool_size + 1'b1);
          used_cnt   <= CW'(used_cnt + 1'b1);
          res_handle <= CW'(pool_size + 1'b1);
          state      <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            m_tdata    <= {free_x[6:0], total_x[6:0], hnd_out_x[6:0], res_status};
            m_tvalid   <= 1'b1;
            clr_report <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/fbpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/fixed_block_pool_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit_tb
// Self-checking bench for the block pool allocator. A queue of commands (a
// short directed opening, then bursts of fills, churn, inits, releases and
// noise) feeds a stream driver. Every accepted command beat runs through a
// bookkeeping model of the pool, and the monitor checks each result beat
// field by field against the oldest prediction. Both sides idle at random,
// and the receiver holds off once for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit_tb;
  import fbpa_pkg::*;

  localparam int unsigned POOL_CAP     = MAX_BLOCKS_DEF;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned HOLD_AT_BEAT = 700;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MODE_SPAN    = 150;
  localparam int unsigned MAX_PRINTS   = 50;

  // Codes the block treats as no-ops.
  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [6:0] handle;
    logic [9:0] request;
    logic [2:0] cmd;
  } pool_cmd_t;

  typedef struct packed {
    logic [6:0] free_cnt;
    logic [6:0] total_cnt;
    logic [6:0] handle;
    logic [2:0] status;
  } pool_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // cmd[2:0], block_request[12:3], handle_in[19:13], zero fill
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // status[2:0], handle_out[9:3], total_blocks[16:10], free_blocks[23:17]
  logic [M_TDATA_W-1:0] m_tdata;

  pool_cmd_t    pending_cmds[$];
  pool_result_t expected_results[$];

  // Model of the pool: its length and one in-use flag per block.
  int unsigned          pool_len;
  logic [POOL_CAP-1:0]  blk_used;

  int unsigned total_cmds;
  int unsigned beats_taken;
  int unsigned beats_seen;
  int unsigned err_count;
  int unsigned tx_gap;
  int unsigned tx_items;
  bit          tx_calm;
  int unsigned rx_wait;
  bit          rx_calm;
  int unsigned idle_cycles;

  fixed_block_pool_allocator_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned gap_draw(input bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got_v,
                             input logic [6:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                beats_seen, name, got_v, want_v));
  endtask

  // Applies one command to the pool model and returns the result it gives.
  task automatic predict_pool(input pool_cmd_t c, output pool_result_t r);
    int unsigned idx;
    int unsigned nfree;
    r        = '0;
    r.status = ST_OK;
    case (c.cmd)
      CMD_INIT: begin
        blk_used = '0;
        if (c.request > POOL_CAP) begin
          pool_len = POOL_CAP;
          r.status = ST_NO_CAPACITY;
        end else begin
          pool_len = 32'(c.request);
        end
      end
      CMD_ALLOC: begin
        for (idx = 0; idx < POOL_CAP; idx++) begin
          if (r.handle == 0 && idx < pool_len && !blk_used[idx]) begin
            blk_used[idx] = 1'b1;
            r.handle      = 7'(idx + 1);
          end
        end
        // No free block: grow the pool by one, unless it is already full.
        if (r.handle == 0) begin
          if (pool_len < POOL_CAP) begin
            blk_used[pool_len] = 1'b1;
            pool_len++;
            r.handle = pool_len[6:0];
          end else begin
            r.status = ST_NO_CAPACITY;
          end
        end
      end
      CMD_FREE: begin
        if (c.handle == 0) r.status = ST_BAD_HANDLE;
        else if (c.handle > pool_len) r.status = ST_NOT_FOUND;
        else blk_used[c.handle - 1] = 1'b0;
      end
      CMD_RELEASE: begin
        if (blk_used != '0) begin
          r.status = ST_IN_USE;
        end else begin
          pool_len = 0;
          blk_used = '0;
        end
      end
      CMD_FORCE: begin
        pool_len = 0;
        blk_used = '0;
      end
      default: begin
      end
    endcase
    nfree = 0;
    for (idx = 0; idx < POOL_CAP; idx++)
      if (idx < pool_len && !blk_used[idx]) nfree++;
    r.total_cnt = pool_len[6:0];
    r.free_cnt  = nfree[6:0];
  endtask

  task automatic push_cmd(input logic [2:0] cmd, input logic [9:0] req,
                          input logic [6:0] h);
    pending_cmds.push_back(pool_cmd_t'({h, req, cmd}));
  endtask

  // Mostly a handle in 1..span, sometimes null or beyond any pool.
  function automatic logic [6:0] pick_handle(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 7'd0;
    if (roll == 1) return 7'($urandom_range(POOL_CAP + 1, 127));
    return 7'($urandom_range(1, span));
  endfunction

  // Sender: one command beat at a time, with a drawn gap after each.
  always @(posedge clk) begin : drive
    pool_result_t predicted;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      tx_gap   <= 0;
      pool_len = 0;
      blk_used = '0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_pool(pool_cmd_t'(s_tdata[19:0]), predicted);
        expected_results.push_back(predicted);
        beats_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap   <= tx_gap - 1;
        end else if (pending_cmds.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {4'b0, pending_cmds.pop_front()};
          tx_items++;
          if (tx_items % MODE_SPAN == 0) tx_calm = ($urandom_range(0, 2) == 0);
          tx_gap <= gap_draw(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat, then drops ready for a drawn gap.
  always @(posedge clk) begin : watch
    pool_result_t got;
    pool_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = pool_result_t'(m_tdata);
        beats_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending (data %h)",
                                    beats_seen, m_tdata));
        end else begin
          want = expected_results.pop_front();
          check_field("status", 7'(got.status), 7'(want.status));
          check_field("handle_out", got.handle, want.handle);
          check_field("total_blocks", got.total_cnt, want.total_cnt);
          check_field("free_blocks", got.free_cnt, want.free_cnt);
        end
        if (beats_seen % MODE_SPAN == 0) rx_calm = ($urandom_range(0, 2) == 0);
        // One long hold-off lets the block fill up and stall its input.
        rx_wait = (beats_seen == HOLD_AT_BEAT) ? HOLD_CYCLES : gap_draw(rx_calm);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned len;
    int unsigned span;
    int unsigned n;

    // Directed opening.
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_FREE, 10'd1023, 7'd0);
    push_cmd(CMD_FREE, 10'd0, 7'd127);
    push_cmd(CMD_RELEASE, 10'd0, 7'd0);
    push_cmd(CMD_FREE, 10'd0, 7'd1);
    push_cmd(CMD_FREE, 10'd0, 7'd1);
    push_cmd(CMD_RELEASE, 10'd1023, 7'd127);
    push_cmd(CMD_INIT, 10'd1023, 7'd0);
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_FREE, 10'd0, 7'd64);
    push_cmd(CMD_FREE, 10'd0, 7'd65);
    push_cmd(CMD_FORCE, 10'd0, 7'd0);
    push_cmd(CMD_INIT, 10'd65, 7'd0);
    push_cmd(CMD_INIT, 10'd64, 7'd0);
    push_cmd(CMD_INIT, 10'd0, 7'd0);
    push_cmd(CMD_INIT, 10'd3, 7'd0);
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_FREE, 10'd0, 7'd2);
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_ALLOC, 10'd0, 7'd0);
    push_cmd(CMD_SPARE_LO, 10'd1023, 7'd127);
    push_cmd(CMD_SPARE_MID, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
    push_cmd(CMD_SPARE_HI, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));

    // Random bursts. Unused fields always carry random garbage.
    n = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < n) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // Fill run: mostly allocs, with an occasional free.
          len  = $urandom_range(40, 80);
          span = $urandom_range(1, POOL_CAP);
          repeat (len) begin
            if ($urandom_range(0, 9) == 0)
              push_cmd(CMD_FREE, 10'($urandom_range(0, 1023)), pick_handle(span));
            else
              push_cmd(CMD_ALLOC, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
          end
        end
        2, 3, 4, 5: begin
          len  = $urandom_range(20, 60);
          span = $urandom_range(2, POOL_CAP);
          repeat (len) begin
            if ($urandom_range(0, 1) == 0)
              push_cmd(CMD_ALLOC, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
            else
              push_cmd(CMD_FREE, 10'($urandom_range(0, 1023)), pick_handle(span));
          end
        end
        6: begin
          if ($urandom_range(0, 7) == 0) span = $urandom_range(0, 1023);
          else span = $urandom_range(0, POOL_CAP);
          push_cmd(CMD_INIT, 10'(span), 7'($urandom_range(0, 127)));
          len  = $urandom_range(10, 30);
          span = (span > POOL_CAP || span < 2) ? POOL_CAP : span;
          repeat (len) begin
            if ($urandom_range(0, 1) == 0)
              push_cmd(CMD_ALLOC, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
            else
              push_cmd(CMD_FREE, 10'($urandom_range(0, 1023)), pick_handle(span));
          end
        end
        7: begin
          repeat ($urandom_range(0, 3))
            push_cmd(CMD_FREE, 10'($urandom_range(0, 1023)), pick_handle(POOL_CAP));
          if ($urandom_range(0, 2) == 0)
            push_cmd(CMD_FORCE, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
          else
            push_cmd(CMD_RELEASE, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)));
        end
        default: begin
          repeat ($urandom_range(5, 15))
            push_cmd(3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)),
                     7'($urandom_range(0, 127)));
        end
      endcase
    end
    total_cmds = pending_cmds.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken < total_cmds || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== fixed_block_pool_allocator_unit.f =====
sv/fbpa_pkg.sv
sv/fbpa_ram.sv
sv/fixed_block_pool_allocator_unit.sv
tb/fixed_block_pool_allocator_unit_tb.sv
